@@ src/round_robin_sleep_scheduler_core_assert.svh @@
// Assertion macros used by the scheduler controller.
// They sample on the rising edge of clock and are off while reset is high.
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRSS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

@@ src/rrss_pkg.sv @@
`timescale 1ns / 1ps
package rrss_pkg;

   localparam int TASK_SLOTS_DEFAULT = 8;
   localparam int OP_W               = 2;
   localparam int TASK_ID_W          = 3;
   localparam int TICK_W             = 32;
   localparam int REQ_DATA_W         = 40;
   localparam int RSP_DATA_W         = 48;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_SLEEP = 2'd1,
      OP_INIT  = 2'd2,
      OP_START = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_RUNNABLE = 2'd1,
      SLOT_SLEEPING = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_PICK = 2'd2
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic pick;
   } cmd_type;

endpackage

@@ src/rrss_pick.sv @@
`timescale 1ns / 1ps
// Round-robin finder: the first runnable slot at or above start, else the
// lowest runnable slot overall.
module rrss_pick import rrss_pkg::*; #(
   parameter int SLOTS  = TASK_SLOTS_DEFAULT,
   parameter int SLOT_W = $clog2(TASK_SLOTS_DEFAULT)
) (
   input  logic [SLOTS-1:0]  runnable,
   input  logic [SLOT_W-1:0] start,
   output logic              found,
   output logic [SLOT_W-1:0] slot
);

   logic [SLOTS-1:0] upper_mask;
   logic [SLOTS-1:0] masked;
   logic [SLOTS-1:0] pool;
   logic [SLOTS-1:0] lowest;

   always_comb begin
      upper_mask = {SLOTS{1'b1}} << start;
      masked     = runnable & upper_mask;
      pool       = (|masked) ? masked : runnable;
      // Isolate the lowest set bit.
      lowest     = pool & (~pool + {{(SLOTS-1){1'b0}}, 1'b1});
      found      = |runnable;
      slot       = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (lowest[i]) begin
            slot = slot | SLOT_W'(i);
         end
      end
   end

endmodule

@@ src/rrss_datapath.sv @@
`timescale 1ns / 1ps
module rrss_datapath import rrss_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT,
   parameter int SLOT_W     = $clog2(TASK_SLOTS_DEFAULT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  op_type                req_op,
   input  logic [TASK_ID_W-1:0]  req_task_id,
   input  logic [TICK_W-1:0]     req_sleep_ticks,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
   localparam int RSP_PAD_W = RSP_DATA_W - (2 * TASK_ID_W + 3 + TICK_W);

   // Captured request.
   op_type               op_ff;
   logic [TASK_ID_W-1:0] id_ff;
   logic [TICK_W-1:0]    ticks_ff;

   // Scheduler state.
   slot_state_type       slot_state_ff [TASK_SLOTS];
   slot_state_type       slot_state_in [TASK_SLOTS];
   logic [TICK_W-1:0]    wake_ff       [TASK_SLOTS];
   logic [TICK_W-1:0]    wake_in       [TASK_SLOTS];
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [SLOT_W-1:0]    cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [SLOT_W-1:0]    prev_ff, prev_in;
   logic                 had_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [TICK_W-1:0]    tick_inc;
   logic [TICK_W-1:0]    sleep_wake;
   logic [TASK_SLOTS-1:0] runnable;
   logic [SLOT_W-1:0]    pick_start;
   logic                 pick_found;
   logic [SLOT_W-1:0]    pick_slot;
   logic                 do_pick;
   logic                 found;
   logic                 switch_now;
   logic [SLOT_W+TASK_ID_W-1:0] run_wide;
   logic [SLOT_W+TASK_ID_W-1:0] prev_wide;

   // Execute step: tick and wake, sleep, or init.
   always_comb begin
      tick_inc   = tick_ff + TICK_W'(1);
      sleep_wake = tick_ff + ticks_ff;
      tick_in    = tick_ff;
      prev_in    = cur_valid_ff ? cur_ff : '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         slot_state_in[i] = slot_state_ff[i];
         wake_in[i]       = wake_ff[i];
      end
      case (op_ff)
         OP_TICK: begin
            tick_in = tick_inc;
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (slot_state_ff[i] == SLOT_SLEEPING && wake_ff[i] <= tick_inc) begin
                  slot_state_in[i] = SLOT_RUNNABLE;
               end
            end
         end
         OP_SLEEP: begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (cur_valid_ff && cur_ff == SLOT_W'(i)) begin
                  slot_state_in[i] = SLOT_SLEEPING;
                  wake_in[i]       = sleep_wake;
               end
            end
         end
         OP_INIT: begin
            // Ids beyond the last slot match no entry and are dropped.
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (int'(id_ff) == i) begin
                  slot_state_in[i] = SLOT_RUNNABLE;
                  wake_in[i]       = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Pick step.
   always_comb begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         runnable[i] = (slot_state_ff[i] == SLOT_RUNNABLE);
      end
      if (op_ff == OP_START || !cur_valid_ff || cur_ff == LAST_SLOT) begin
         pick_start = '0;
      end else begin
         pick_start = cur_ff + SLOT_W'(1);
      end
   end

   rrss_pick #(
      .SLOTS  (TASK_SLOTS),
      .SLOT_W (SLOT_W)
   ) u_pick (
      .runnable (runnable),
      .start    (pick_start),
      .found    (pick_found),
      .slot     (pick_slot)
   );

   always_comb begin
      do_pick      = (op_ff == OP_TICK) || (op_ff == OP_START) ||
                     (op_ff == OP_SLEEP && had_ff);
      found        = do_pick && pick_found;
      cur_in       = found ? pick_slot : cur_ff;
      cur_valid_in = cur_valid_ff || found;
      if (op_ff == OP_START) begin
         switch_now = found;
      end else begin
         switch_now = found && had_ff && (pick_slot != cur_ff);
      end
      run_wide     = {{TASK_ID_W{1'b0}}, (cur_valid_in ? cur_in : {SLOT_W{1'b0}})};
      prev_wide    = {{TASK_ID_W{1'b0}}, prev_ff};
      rsp_data_in  = {{RSP_PAD_W{1'b0}}, tick_ff, prev_wide[TASK_ID_W-1:0], switch_now,
                      found, cur_valid_in, run_wide[TASK_ID_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_EMPTY;
         end
         tick_ff      <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               slot_state_ff[i] <= slot_state_in[i];
            end
            tick_ff <= tick_in;
         end
         if (cmd.pick) begin
            cur_ff       <= cur_in;
            cur_valid_ff <= cur_valid_in;
         end
      end
   end

   // Payload registers; a wake tick is only read while its slot sleeps.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         id_ff    <= req_task_id;
         ticks_ff <= req_sleep_ticks;
      end
      if (cmd.exec) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            wake_ff[i] <= wake_in[i];
         end
         prev_ff <= prev_in;
         had_ff  <= cur_valid_ff;
      end
      if (cmd.pick) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

@@ src/rrss_ctrl.sv @@
`timescale 1ns / 1ps
`include "round_robin_sleep_scheduler_core_assert.svh"
module rrss_ctrl import rrss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            // The result leaves for the output register; a new request
            // may be taken on the same edge.
            if (out_free) begin
               cmd.pick   = 1'b1;
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.pick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `RRSS_ASSERT_NEXT(a_load_to_exec, cmd.load, state_ff == ST_EXEC)
   `RRSS_ASSERT_NEXT(a_exec_to_pick, state_ff == ST_EXEC, state_ff == ST_PICK)
   `RRSS_ASSERT_SAME(a_pick_needs_room, cmd.pick, !rsp_valid_ff || rsp_tready)
   `RRSS_ASSERT_NEXT(a_pick_fills_rsp, cmd.pick, rsp_valid_ff)

endmodule

@@ src/round_robin_sleep_scheduler_core.sv @@
`timescale 1ns / 1ps
// A request runs the execute step, then the pick step, which waits until the
// output is free. The next request is taken on the pick edge at the earliest,
// as the execute step and the pick step share the slot state registers.
// Reset (synchronous, active high) empties all slots, zeroes the tick count
// and clears the running task; there is no clearing pass.
module round_robin_sleep_scheduler_core import rrss_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: task_id [2:0], sleep_ticks [34:3], zero pad [39:35].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: operation [1:0].
   input  logic [OP_W-1:0]       req_tuser,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: running_task [2:0], running_valid [3], found [4],
   // switch_now [5], previous_task [8:6], tick_now [40:9], zero pad [47:41].
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);

   cmd_type cmd;

   // The controller sequences each request through three phases: it loads
   // the request, runs the execute step (tick and wake, sleep, or init) and
   // then the round-robin pick, which writes the response register. A new
   // request is taken on the pick edge, so that it need not wait for an idle
   // state; the pick itself waits until the output register is free.
   rrss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds the slot states, the wake ticks, the tick count and
   // the running slot. Wake compares for all slots run in parallel in the
   // execute step; the pick finds the first runnable slot after the running
   // one, wrapping around, or from slot 0 on a start request.
   rrss_datapath #(
      .TASK_SLOTS (TASK_SLOTS),
      .SLOT_W     (SLOT_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (op_type'(req_tuser)),
      .req_task_id     (req_tdata[TASK_ID_W-1:0]),
      .req_sleep_ticks (req_tdata[TASK_ID_W+TICK_W-1:TASK_ID_W]),
      .rsp_data        (rsp_tdata)
   );

endmodule
